[design/biquad_lowpass_filter_core_assert.svh]
// assertion macros for the biquad filter core
`ifndef BIQUAD_LOWPASS_FILTER_CORE_ASSERT_SVH
`define BIQUAD_LOWPASS_FILTER_CORE_ASSERT_SVH

// antecedent and consequent in the same cycle
`define BLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define BLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/blf_pkg.sv]
// shared types and constants of the biquad filter core
`timescale 1ns / 1ps

package blf_pkg;

    localparam int CHANNELS       = 8;
    localparam int SAMPLE_BITS    = 16;
    localparam int HIST_FRAC      = 8;
    localparam int HIST_BITS      = SAMPLE_BITS + HIST_FRAC;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC      = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CH_BITS        = 3;
    localparam int ADDR_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_BITS      = COEF_BITS + HIST_BITS;
    localparam int ACC_BITS       = PROD_BITS + 3;
    localparam int RND_BITS       = ACC_BITS - COEF_FRAC;
    localparam int MEM_BITS       = 2 * SAMPLE_BITS + 2 * HIST_BITS;
    localparam int STEP_BITS      = 3;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [STEP_BITS-1:0] step_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [HIST_BITS-1:0] hist_t;
    typedef logic signed [ACC_BITS-1:0] acc_t;

    // register map
    localparam cfg_index_t REG_B0 = cfg_index_t'(0);
    localparam cfg_index_t REG_B1 = cfg_index_t'(1);
    localparam cfg_index_t REG_B2 = cfg_index_t'(2);
    localparam cfg_index_t REG_A1 = cfg_index_t'(3);
    localparam cfg_index_t REG_A2 = cfg_index_t'(4);

    // multiply-accumulate steps
    localparam step_t STEP_X0 = step_t'(0);
    localparam step_t STEP_X1 = step_t'(1);
    localparam step_t STEP_X2 = step_t'(2);
    localparam step_t STEP_Y1 = step_t'(3);
    localparam step_t STEP_Y2 = step_t'(4);

    localparam coef_t COEF_B0_RESET = coef_t'(1 << COEF_FRAC);

    localparam acc_t ROUND_HALF = acc_t'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [HIST_BITS:0] OUT_HALF = (HIST_BITS + 1)'(1) <<< (HIST_FRAC - 1);

    localparam hist_t HIST_MAX = hist_t'({1'b0, {(HIST_BITS - 1){1'b1}}});
    localparam hist_t HIST_MIN = hist_t'({1'b1, {(HIST_BITS - 1){1'b0}}});
    localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
    localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS - 1){1'b0}}});

    // one history memory word per channel
    typedef struct packed {
        hist_t   y2;
        hist_t   y1;
        sample_t x2;
        sample_t x1;
    } hist_word_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MAC,
        PH_LAST,
        PH_ROUND
    } phase_t;

endpackage

[design/blf_ram.sv]
// generic single-clock ram with one write port and a registered read port
`timescale 1ns / 1ps

module blf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/biquad_lowpass_filter_core.sv]
// top level of the multi-channel direct form I biquad filter
//
//   port group   dir  handshake            carries
//   s_*          in   s_valid / s_ready    action, channel, sample
//   m_*          out  m_valid / m_ready    channel_out, filtered
//   cfg_*        in   cfg_valid / cfg_ready coefficient index and data
//
// one item at a time in the core: one history read, five products on a single
// shared 18x24 multiplier, a final accumulate, then round, saturate and write-back
// m_valid rises when the write-back state loads the output register for the item
// reset clears control, the per-channel valid bits and all coefficients but b0, so history
// reads as zero until a channel is first written; no clearing pass is needed
// a one-item input buffer and the output register keep both sides moving while
// a result waits on m_ready; the write-back cycle stalls only if it stays full
`timescale 1ns / 1ps
`include "biquad_lowpass_filter_core_assert.svh"

module biquad_lowpass_filter_core
    import blf_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [CH_BITS-1:0]        s_channel,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CH_BITS-1:0]        m_channel_out,
    output logic signed [SAMPLE_BITS-1:0] m_filtered,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data
);

    // coefficient registers
    coef_t coef_b0_reg;
    coef_t coef_b1_reg;
    coef_t coef_b2_reg;
    coef_t coef_a1_reg;
    coef_t coef_a2_reg;

    // input buffer
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic               pend_action_reg;
    logic [CH_BITS-1:0] pend_ch_reg;
    sample_t            pend_sample_reg;

    // item in the core
    logic               cur_action_reg;
    logic [CH_BITS-1:0] cur_ch_reg;
    sample_t            cur_sample_reg;
    logic               cur_in_range;

    // sequencer
    phase_t phase_reg;
    phase_t phase_next;
    step_t  step_reg;
    step_t  step_next;
    logic   take;
    logic   ram_re;
    logic   ram_we;
    logic   m_load;
    logic   out_free;

    // history memory and per-channel valid bits
    logic [ADDR_BITS-1:0] ram_addr;
    logic [MEM_BITS-1:0]  ram_rdata;
    logic [MEM_BITS-1:0]  ram_wdata;
    logic [CHANNELS-1:0]  ent_valid_reg;
    logic                 rd_valid_reg;
    hist_word_t           hist;
    hist_word_t           hist_wr;

    // datapath
    coef_t                       mul_coef;
    hist_t                       mul_data;
    logic                        mul_b_term;
    logic                        mul_sub;
    logic signed [PROD_BITS-1:0] mul_full;
    logic signed [PROD_BITS-1:0] mul_aligned;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        prod_sub_reg;
    acc_t                        acc_reg;
    acc_t                        prod_ext;
    acc_t                        acc_sum;

    // rounding
    logic signed [RND_BITS-1:0]    y_wide;
    logic                          y_fits;
    hist_t                         y_new;
    logic signed [HIST_BITS:0]     o_sum;
    logic signed [SAMPLE_BITS:0]   o_wide;
    sample_t                       o_sat;
    sample_t                       res_filtered;

    // output register
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [CH_BITS-1:0] m_channel_reg;
    sample_t            m_filtered_reg;

    // ---------------------------------------------------------------
    // configuration: always ready, writes beyond the map are dropped
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg <= COEF_B0_RESET;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_B0:  coef_b0_reg <= coef_t'(cfg_data);
                REG_B1:  coef_b1_reg <= coef_t'(cfg_data);
                REG_B2:  coef_b2_reg <= coef_t'(cfg_data);
                REG_A1:  coef_a1_reg <= coef_t'(cfg_data);
                REG_A2:  coef_a2_reg <= coef_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input buffer: takes an item whenever it is empty
    // ---------------------------------------------------------------
    assign s_ready = !pend_valid_reg;
    assign pend_valid_next = pend_valid_reg ? !take : s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pend_action_reg <= s_action;
            pend_ch_reg     <= s_channel;
            pend_sample_reg <= s_sample;
        end
        if (take) begin
            cur_action_reg <= pend_action_reg;
            cur_ch_reg     <= pend_ch_reg;
            cur_sample_reg <= pend_sample_reg;
        end
    end

    // channels past the configured count leave the state alone and give 0
    assign cur_in_range = 32'(cur_ch_reg) < 32'(CHANNELS);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (pend_valid_reg) begin
                    phase_next = PH_MAC;
                    step_next  = STEP_X0;
                end
            end
            PH_MAC: begin
                if (step_reg == STEP_Y2) begin
                    phase_next = PH_LAST;
                end else begin
                    step_next = step_t'(step_reg + 1'b1);
                end
            end
            PH_LAST: begin
                phase_next = PH_ROUND;
            end
            PH_ROUND: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        phase_next = PH_MAC;
                        step_next  = STEP_X0;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        take   = 1'b0;
        ram_re = 1'b0;
        ram_we = 1'b0;
        m_load = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                take = pend_valid_reg;
            end
            PH_MAC: begin
                // history read at the first step, held for the rest of the item
                ram_re = (step_reg == STEP_X0);
            end
            PH_LAST: ;
            PH_ROUND: begin
                // write-back lands before the next item's read: no forwarding needed
                m_load = out_free;
                ram_we = out_free && cur_in_range;
                take   = out_free && pend_valid_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            step_reg  <= STEP_X0;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    // ---------------------------------------------------------------
    // history memory, one word per channel
    // ---------------------------------------------------------------
    assign ram_addr = ADDR_BITS'(cur_ch_reg);

    blf_ram #(
        .WIDTH (MEM_BITS),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // a channel never written since reset reads as all-zero history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (ram_we) begin
                ent_valid_reg[ram_addr] <= 1'b1;
            end
            if (ram_re) begin
                rd_valid_reg <= ent_valid_reg[ram_addr];
            end
        end
    end

    assign hist = rd_valid_reg ? hist_word_t'(ram_rdata) : hist_word_t'('0);

    // ---------------------------------------------------------------
    // shared multiplier and accumulator
    // ---------------------------------------------------------------
    always_comb begin
        mul_coef   = coef_b0_reg;
        mul_data   = {{(HIST_BITS - SAMPLE_BITS){cur_sample_reg[SAMPLE_BITS-1]}},
                      cur_sample_reg};
        mul_b_term = 1'b1;
        mul_sub    = 1'b0;
        unique case (step_reg)
            STEP_X0: ;
            STEP_X1: begin
                mul_coef = coef_b1_reg;
                mul_data = {{(HIST_BITS - SAMPLE_BITS){hist.x1[SAMPLE_BITS-1]}}, hist.x1};
            end
            STEP_X2: begin
                mul_coef = coef_b2_reg;
                mul_data = {{(HIST_BITS - SAMPLE_BITS){hist.x2[SAMPLE_BITS-1]}}, hist.x2};
            end
            STEP_Y1: begin
                mul_coef   = coef_a1_reg;
                mul_data   = hist.y1;
                mul_b_term = 1'b0;
                mul_sub    = 1'b1;
            end
            STEP_Y2: begin
                mul_coef   = coef_a2_reg;
                mul_data   = hist.y2;
                mul_b_term = 1'b0;
                mul_sub    = 1'b1;
            end
            default: ;
        endcase
    end

    assign mul_full = PROD_BITS'(mul_coef) * PROD_BITS'(mul_data);
    // input terms carry 16 fraction bits, output terms 24: align to 24
    assign mul_aligned = mul_b_term ? (mul_full <<< HIST_FRAC) : mul_full;

    assign prod_ext = {{(ACC_BITS - PROD_BITS){prod_reg[PROD_BITS-1]}}, prod_reg};
    assign acc_sum  = prod_sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);

    always_ff @(posedge aclk) begin
        if (phase_reg == PH_MAC) begin
            prod_reg     <= mul_aligned;
            prod_sub_reg <= mul_sub;
            // the rounding half is preloaded so the last cycle needs no extra add
            if (step_reg == STEP_X0) begin
                acc_reg <= ROUND_HALF;
            end else begin
                acc_reg <= acc_sum;
            end
        end else if (phase_reg == PH_LAST) begin
            acc_reg <= acc_sum;
        end
    end

    // ---------------------------------------------------------------
    // round to history precision, then to the output integer
    // ---------------------------------------------------------------
    assign y_wide = acc_reg[ACC_BITS-1:COEF_FRAC];
    assign y_fits = (y_wide[RND_BITS-1:HIST_BITS-1] == '0)
                 || (y_wide[RND_BITS-1:HIST_BITS-1] == '1);

    always_comb begin
        if (y_fits) begin
            y_new = y_wide[HIST_BITS-1:0];
        end else if (y_wide[RND_BITS-1]) begin
            y_new = HIST_MIN;
        end else begin
            y_new = HIST_MAX;
        end
    end

    assign o_sum  = {y_new[HIST_BITS-1], y_new} + OUT_HALF;
    assign o_wide = o_sum[HIST_BITS:HIST_FRAC];

    always_comb begin
        if (o_wide[SAMPLE_BITS] == o_wide[SAMPLE_BITS-1]) begin
            o_sat = o_wide[SAMPLE_BITS-1:0];
        end else if (o_wide[SAMPLE_BITS]) begin
            o_sat = SAMPLE_MIN;
        end else begin
            o_sat = SAMPLE_MAX;
        end
    end

    assign res_filtered = (cur_action_reg || !cur_in_range) ? sample_t'('0) : o_sat;

    // shifted history, or all zero on a clear
    always_comb begin
        if (cur_action_reg) begin
            hist_wr = '0;
        end else begin
            hist_wr.y2 = hist.y1;
            hist_wr.y1 = y_new;
            hist_wr.x2 = hist.x1;
            hist_wr.x1 = cur_sample_reg;
        end
    end

    assign ram_wdata = MEM_BITS'(hist_wr);

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    assign m_valid_next = m_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_channel_reg  <= cur_ch_reg;
            m_filtered_reg <= res_filtered;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_reg;
    assign m_filtered    = m_filtered_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `BLF_ASSERT_NOW(a_no_rw_overlap, ram_re, !ram_we, "history read and write in one cycle")
    `BLF_ASSERT_NEXT(a_single_read, ram_re, !ram_re, "history read repeated within an item")
    `BLF_ASSERT_NEXT(a_result_posted, m_load, m_valid_reg, "result not posted after write-back")
    `BLF_ASSERT_NEXT(a_clear_zero, m_load && cur_action_reg, m_filtered == '0, "clear gave nonzero")

endmodule

[bench/blf_checker.sv]
// result checker for the biquad filter core: predicts every item and compares
`timescale 1ns / 1ps

module blf_checker
    import blf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_action,
    input  logic [CH_BITS-1:0]            s_channel,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [CH_BITS-1:0]            m_channel_out,
    input  logic signed [SAMPLE_BITS-1:0] m_filtered,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data,
    output int                            mismatch_count,
    output int                            results_owed
);

    typedef struct {
        logic [CH_BITS-1:0] channel;
        sample_t            filtered;
    } filter_result_t;

    localparam longint FEED_ALIGN = longint'(1) <<< HIST_FRAC;
    localparam longint HIST_ROUND = longint'(1) <<< (COEF_FRAC - 1);
    localparam longint OUT_ROUND  = longint'(1) <<< (HIST_FRAC - 1);

    coef_t   coef [REG_B0:REG_A2];
    sample_t x_one [CHANNELS];
    sample_t x_two [CHANNELS];
    hist_t   y_one [CHANNELS];
    hist_t   y_two [CHANNELS];

    filter_result_t owed_outputs [$];
    int errors = 0;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // one direct form I step, updates the channel history
    function automatic sample_t filter_sample(input int ch, input sample_t x);
        longint acc;
        longint y_hist;
        longint y_out;
        acc = longint'(coef[REG_B0]) * longint'(x) * FEED_ALIGN
            + longint'(coef[REG_B1]) * longint'(x_one[ch]) * FEED_ALIGN
            + longint'(coef[REG_B2]) * longint'(x_two[ch]) * FEED_ALIGN
            - longint'(coef[REG_A1]) * longint'(y_one[ch])
            - longint'(coef[REG_A2]) * longint'(y_two[ch]);
        y_hist = (acc + HIST_ROUND) >>> COEF_FRAC;
        if (y_hist > longint'(HIST_MAX)) y_hist = longint'(HIST_MAX);
        if (y_hist < longint'(HIST_MIN)) y_hist = longint'(HIST_MIN);
        x_two[ch] = x_one[ch];
        x_one[ch] = x;
        y_two[ch] = y_one[ch];
        y_one[ch] = hist_t'(y_hist);
        y_out = (y_hist + OUT_ROUND) >>> HIST_FRAC;
        if (y_out > longint'(SAMPLE_MAX)) y_out = longint'(SAMPLE_MAX);
        if (y_out < longint'(SAMPLE_MIN)) y_out = longint'(SAMPLE_MIN);
        return sample_t'(y_out);
    endfunction

    always @(posedge aclk) begin
        filter_result_t want;
        int ch;
        if (!aresetn) begin
            foreach (coef[i]) coef[i] = '0;
            coef[REG_B0] = COEF_B0_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                x_one[c] = '0;
                x_two[c] = '0;
                y_one[c] = '0;
                y_two[c] = '0;
            end
            owed_outputs.delete();
        end else begin
            // indexes past the last coefficient are dropped
            if (cfg_valid && cfg_ready && cfg_index <= REG_A2)
                coef[cfg_index] = coef_t'(cfg_data);

            if (m_valid && m_ready) begin
                if (owed_outputs.size() == 0) begin
                    report_mismatch($sformatf("result on channel %0d with none outstanding",
                                              m_channel_out));
                end else begin
                    want = owed_outputs.pop_front();
                    if (m_channel_out !== want.channel)
                        report_mismatch($sformatf("channel_out got %0d expected %0d",
                                                  m_channel_out, want.channel));
                    if (m_filtered !== want.filtered)
                        report_mismatch($sformatf("filtered on channel %0d got %0d expected %0d",
                                                  want.channel, m_filtered, want.filtered));
                end
            end

            if (s_valid && s_ready) begin
                ch = int'(s_channel);
                want.channel  = s_channel;
                want.filtered = '0;
                if (ch < CHANNELS) begin
                    if (s_action) begin
                        x_one[ch] = '0;
                        x_two[ch] = '0;
                        y_one[ch] = '0;
                        y_two[ch] = '0;
                    end else begin
                        want.filtered = filter_sample(ch, s_sample);
                    end
                end
                owed_outputs.push_back(want);
            end
        end
        mismatch_count <= errors;
        results_owed   <= owed_outputs.size();
    end

endmodule

[bench/testbench.sv]
// top of the biquad filter core bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import blf_pkg::*;

    // action codes on s_action
    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // register slots past the coefficient list, writes there must be dropped
    localparam cfg_index_t REG_FIRST_SPARE = cfg_index_t'(REG_A2 + 1);
    localparam cfg_index_t REG_LAST_SPARE  = '1;

    localparam coef_t COEF_MAX  = coef_t'({1'b0, {(COEF_BITS - 1){1'b1}}});
    localparam coef_t COEF_MIN  = coef_t'({1'b1, {(COEF_BITS - 1){1'b0}}});
    localparam coef_t COEF_HALF = coef_t'(1 <<< (COEF_FRAC - 1));
    localparam coef_t COEF_LSB  = coef_t'(1);

    // two second-order lowpass designs in Q2.16: low cutoff and high cutoff
    localparam coef_t LP_NARROW [REG_B0:REG_A2] = '{1318, 2636, 1318, -102302, 42035};
    localparam coef_t LP_WIDE   [REG_B0:REG_A2] = '{13540, 27080, 13540, -24216, 12832};

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 240;
    localparam int IDLE_LIMIT  = 4000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE
    } rx_mode_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_action = ACT_FILTER;
    logic [CH_BITS-1:0]            s_channel = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample = '0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [CH_BITS-1:0]            m_channel_out;
    logic signed [SAMPLE_BITS-1:0] m_filtered;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    cfg_index_t                    cfg_index = '0;
    logic [COEF_BITS-1:0]          cfg_data = '0;

    int mismatch_count;
    int results_owed;

    // sender burst bookkeeping and slowly moving per-channel levels
    int      burst_left = 0;
    sample_t channel_level [CHANNELS];

    // receiver stall pattern
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_mode_left = 0;

    int idle_cycles = 0;

    biquad_lowpass_filter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_filtered    (m_filtered),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    blf_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_channel      (s_channel),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_channel_out  (m_channel_out),
        .m_filtered     (m_filtered),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // receiver: switches between always ready, coin flips and long stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_mode      <= RX_OPEN;
            rx_mode_left <= 0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= rx_mode_t'($urandom_range(0, 2));
                rx_mode_left <= $urandom_range(20, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN: begin
                    m_ready <= 1'b1;
                end
                RX_COIN: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    // mostly stalled, lets a result through now and then
                    m_ready <= ($urandom_range(0, 5) == 0);
                end
            endcase
        end
    end

    // watchdog: no handshake of any kind for too long ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("biquad_lowpass_filter_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // present one item, with a random gap first when the current burst is used up;
    // returns at the edge where the item is taken
    task automatic send_item(input logic act, input logic [CH_BITS-1:0] ch, input sample_t smp);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 3)
                gap = 0;
            else if ($urandom_range(0, 19) == 0)
                gap = $urandom_range(20, 40);
            else
                gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_action <= act;
        s_channel <= ch;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold the sender off until every outstanding result has been taken
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    // write all five coefficients back to back, then the spare slots with junk
    task automatic program_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                                 input coef_t a1, input coef_t a2);
        coef_t vals [REG_B0:REG_A2];
        vals = '{b0, b1, b2, a1, a2};
        for (int i = 0; i <= int'(REG_LAST_SPARE); i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            if (i < int'(REG_FIRST_SPARE))
                cfg_data <= vals[i];
            else
                cfg_data <= COEF_BITS'($urandom);
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        coef_t   c [REG_B0:REG_A2];
        logic    act;
        logic [CH_BITS-1:0] ch;
        sample_t smp;
        int unsigned pick;

        foreach (channel_level[i]) channel_level[i] = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset coefficients pass samples straight through: field extremes,
        // alternating bit patterns, every channel index edge, both actions
        send_item(ACT_FILTER, 3'd0, SAMPLE_MAX);
        send_item(ACT_FILTER, 3'd1, SAMPLE_MIN);
        send_item(ACT_FILTER, 3'd2, sample_t'(0));
        send_item(ACT_FILTER, 3'd3, sample_t'(1));
        send_item(ACT_FILTER, 3'd7, sample_t'(-1));
        send_item(ACT_FILTER, 3'd5, sample_t'(16'h5555));
        send_item(ACT_FILTER, 3'd6, sample_t'(16'haaaa));
        send_item(ACT_CLEAR, 3'd0, sample_t'(16'h1234));
        send_item(ACT_CLEAR, 3'd4, SAMPLE_MAX);

        // largest gains with full positive feedback: history and output saturate
        // both ways, a clear in the middle wipes the saturated history
        drain_results();
        program_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        repeat (3) send_item(ACT_FILTER, 3'd0, SAMPLE_MAX);
        repeat (3) send_item(ACT_FILTER, 3'd0, SAMPLE_MIN);
        send_item(ACT_CLEAR, 3'd0, sample_t'(0));
        repeat (2) send_item(ACT_FILTER, 3'd1, SAMPLE_MIN);

        // most negative gains against opposite feedback
        drain_results();
        program_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        repeat (2) send_item(ACT_FILTER, 3'd2, SAMPLE_MAX);
        send_item(ACT_FILTER, 3'd2, SAMPLE_MIN);

        // half gain puts the output rounding exactly on a tie
        drain_results();
        program_coefs(COEF_HALF, '0, '0, '0, '0);
        send_item(ACT_FILTER, 3'd3, sample_t'(1));
        send_item(ACT_FILTER, 3'd3, sample_t'(-1));

        // smallest gain with x = +-128 puts the history rounding on a tie
        drain_results();
        program_coefs(COEF_LSB, '0, '0, '0, '0);
        send_item(ACT_FILTER, 3'd4, sample_t'(128));
        send_item(ACT_FILTER, 3'd4, sample_t'(-128));

        // random phases, each with its own coefficient set
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0, 2: begin
                    // a real lowpass design, jittered a little
                    foreach (c[i])
                        c[i] = coef_t'(int'(($urandom_range(0, 1) ? LP_NARROW[i] : LP_WIDE[i]))
                                       + int'($urandom_range(0, 64)) - 32);
                end
                1: begin
                    foreach (c[i]) c[i] = coef_t'($urandom);
                end
                default: begin
                    foreach (c[i]) begin
                        pick = $urandom_range(0, 3);
                        c[i] = (pick == 0) ? COEF_MAX : (pick == 1) ? COEF_MIN :
                               (pick == 2) ? coef_t'(0) : COEF_B0_RESET;
                    end
                end
            endcase
            drain_results();
            program_coefs(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_A1], c[REG_A2]);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                ch   = CH_BITS'($urandom_range(0, CHANNELS - 1));
                pick = $urandom_range(0, 99);
                act  = (pick < 4) ? ACT_CLEAR : ACT_FILTER;
                if (pick < 40) begin
                    smp = sample_t'($urandom);
                end else if (pick < 65) begin
                    smp = sample_t'(int'($urandom_range(0, 4000)) - 2000);
                end else if (pick < 75) begin
                    smp = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                end else begin
                    // step-like input so the filter settles toward a level
                    if ($urandom_range(0, 15) == 0)
                        channel_level[ch] = sample_t'($urandom);
                    smp = channel_level[ch] + sample_t'(int'($urandom_range(0, 64)) - 32);
                end
                send_item(act, ch, smp);

                // now and then let the core run completely dry mid-phase
                if ($urandom_range(0, 299) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("biquad_lowpass_filter_core test passed");
        else
            $display("biquad_lowpass_filter_core test failed");
        $finish;
    end

endmodule
